/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nms_pkg.sv */
package nms_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIXEL_BITS = 16;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WU_W  = COL_W + 1;

    localparam int PIX_W      = 16;
    localparam int IMG_W_W    = 12;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 11;
    localparam int COUNT_W    = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [IMG_W_W-1:0] IMG_W_RESET = IMG_W_W'(640);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 3);

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH = 1'b0,
        CFG_MARK_VALUE  = 1'b1
    } t_cfg_idx;

    typedef logic [PIXEL_BITS-1:0] t_pix;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             start_of_frame;
        logic             end_of_frame;
    } t_pix_item;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] center_row;
        logic [OUT_COL_W-1:0] center_col;
        logic [PIX_W-1:0]     out_value;
        logic                 is_maximum;
        logic [COUNT_W-1:0]   peak_count;
        logic                 last;
    } t_res_item;

endpackage

/* rtl/nms_cfg_if.sv */
interface nms_cfg_if
    import nms_pkg::*;
();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/nms_pix_if.sv */
interface nms_pix_if
    import nms_pkg::*;
();
    logic      valid;
    logic      ready;
    t_pix_item data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* rtl/nms_res_if.sv */
interface nms_res_if
    import nms_pkg::*;
();
    logic      valid;
    logic      ready;
    t_res_item data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* rtl/nms_ram.sv */
module nms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/nms_3x3_local_maxima.sv */
// channel | dir | handshake         | carries
// i_cfg   | in  | valid/ready       | register index, write data
// i_pix   | in  | valid/ready       | pixel, start_of_frame, end_of_frame
// o_res   | out | valid/ready       | center row/col, value, flag, count, last
//
// One pixel per cycle sustained while the result queue has room; a pixel's result
// passes line store read, window update and compare, then a 4-entry result queue.
// Line stores are registered-read RAMs; a write to the column being read is forwarded.
// Reset clears position, count, window and queue; line stores keep no reset.
// A stalled o_res fills the queue; i_pix.ready drops when in-flight requests
// plus queued results reach the queue depth.
`include "assert_macros.svh"

module nms_3x3_local_maxima
    import nms_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    nms_cfg_if.sink      i_cfg,
    nms_pix_if.sink      i_pix,
    nms_res_if.source    o_res
);
    // configuration
    logic [IMG_W_W-1:0] r_img_w;
    t_pix               r_mark;
    logic [WU_W-1:0]    w_use;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_W_RESET;
            r_mark  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IMAGE_WIDTH: r_img_w <= i_cfg.data[IMG_W_W-1:0];
                CFG_MARK_VALUE:  r_mark  <= i_cfg.data[PIXEL_BITS-1:0];
                default:         r_img_w <= r_img_w;
            endcase
        end
    end

    always_comb begin
        if (32'(r_img_w) < 3) begin
            w_use = WU_W'(3);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            w_use = WU_W'(MAX_WIDTH);
        end else begin
            w_use = WU_W'(r_img_w);
        end
    end

    // stage 0: position, line store read
    logic             in_acc;
    logic [COL_W-1:0] r_col, n_col, col_base, col0;
    logic [ROW_W-1:0] r_row, n_row, row0;
    logic [WU_W-1:0]  col_inc;
    t_pix             p0;
    logic             fwd0;

    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    t_pix             r_s1_p;
    logic             r_s1_sof, r_s1_eof, r_s1_fwd;
    t_pix             r_s1_ftop, r_s1_fmid;

    logic             r_s2_valid;
    logic [COL_W-1:0] r_s2_col;
    logic [ROW_W-1:0] r_s2_row;
    logic             r_s2_sof, r_s2_eof;

    logic [CNT_W-1:0] r_fcnt;

    assign in_acc = i_pix.valid && i_pix.ready;
    assign p0     = i_pix.data.pixel[PIXEL_BITS-1:0];
    assign i_pix.ready = (CNT_W'(r_s1_valid) + CNT_W'(r_s2_valid) + r_fcnt)
                         < CNT_W'(FIFO_DEPTH);

    always_comb begin
        col_base = i_pix.data.start_of_frame ? '0 : r_col;
        row0     = i_pix.data.start_of_frame ? '0 : r_row;
        col0     = ({1'b0, col_base} >= w_use) ? '0 : col_base;
        col_inc  = {1'b0, col0} + 1'b1;
        n_col    = r_col;
        n_row    = r_row;
        if (in_acc) begin
            if (i_pix.data.end_of_frame) begin
                n_col = '0;
                n_row = '0;
            end else if (col_inc >= w_use) begin
                n_col = '0;
                n_row = (32'(row0) < MAX_HEIGHT - 1) ? row0 + 1'b1 : row0;
            end else begin
                n_col = col_inc[COL_W-1:0];
                n_row = row0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign fwd0 = r_s1_valid && (r_s1_col == col0);

    // stage 1: line store data, write back, window shift
    t_pix above_q, middle_q, top1, mid1;
    t_pix r_win [9];

    assign top1 = r_s1_fwd ? r_s1_ftop : above_q;
    assign mid1 = r_s1_fwd ? r_s1_fmid : middle_q;

    nms_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_above (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (mid1),
        .i_raddr (col0),
        .o_rdata (above_q)
    );

    nms_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_p),
        .i_raddr (col0),
        .o_rdata (middle_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
        r_s1_col  <= col0;
        r_s1_row  <= row0;
        r_s1_p    <= p0;
        r_s1_sof  <= i_pix.data.start_of_frame;
        r_s1_eof  <= i_pix.data.end_of_frame;
        r_s1_fwd  <= fwd0;
        r_s1_ftop <= mid1;
        r_s1_fmid <= r_s1_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3]     <= r_win[k*3 + 1];
                r_win[k*3 + 1] <= r_win[k*3 + 2];
            end
            r_win[2] <= top1;
            r_win[5] <= mid1;
            r_win[8] <= r_s1_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_col <= r_s1_col;
        r_s2_row <= r_s1_row;
        r_s2_sof <= r_s1_sof;
        r_s2_eof <= r_s1_eof;
    end

    // stage 2: compare, count, queue
    logic [COUNT_W-1:0] r_total, cnt_base, cnt_new;
    logic               s2_push, is_max;
    t_pix               center, value;
    t_res_item          res;

    assign s2_push = r_s2_valid && (32'(r_s2_row) >= 2) && (32'(r_s2_col) >= 2);
    assign center  = r_win[4];

    always_comb begin
        is_max = 1'b1;
        for (int k = 0; k < 9; k++) begin
            if (k != 4 && !(center > r_win[k])) begin
                is_max = 1'b0;
            end
        end
        cnt_base = r_s2_sof ? '0 : r_total;
        cnt_new  = (is_max && cnt_base != COUNT_MAX) ? cnt_base + 1'b1 : cnt_base;
        value    = is_max ? ((r_mark != '0) ? r_mark : center) : '0;

        res.center_row = OUT_ROW_W'(r_s2_row - 1'b1);
        res.center_col = OUT_COL_W'(r_s2_col - 1'b1);
        res.out_value  = PIX_W'(value);
        res.is_maximum = is_max;
        res.peak_count = cnt_new;
        res.last       = r_s2_eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (r_s2_valid) begin
            if (r_s2_eof) begin
                r_total <= '0;
            end else if (s2_push) begin
                r_total <= cnt_new;
            end else begin
                r_total <= cnt_base;
            end
        end
    end

    t_res_item          r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic               f_pop;

    assign f_pop       = o_res.valid && o_res.ready;
    assign o_res.valid = (r_fcnt != '0);
    assign o_res.data  = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
        end else begin
            if (s2_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (f_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_fcnt <= r_fcnt + CNT_W'(s2_push) - CNT_W'(f_pop);
        end
        if (s2_push) begin
            r_fifo[r_wp] <= res;
        end
    end

    logic s1_col_ok;
    logic push_only;
    logic fifo_full;
    assign s1_col_ok = ({1'b0, r_s1_col} < w_use);
    assign push_only = s2_push && !f_pop;
    assign fifo_full = (r_fcnt == CNT_W'(FIFO_DEPTH));

    `NMS_ASSERT_IMP(a_fifo_no_overflow, i_clk, i_rst_n, push_only, !fifo_full, "queue overflow")
    `NMS_ASSERT_IMP(a_col_in_range, i_clk, i_rst_n, r_s1_valid, s1_col_ok, "column beyond width")
    `NMS_ASSERT_NXT(a_push_visible, i_clk, i_rst_n, s2_push, o_res.valid, "result not presented")

endmodule
